@@ src/framebuffer_shape_fill_assert.svh @@
// Assertion macros for the checker of the frame store block.
`ifndef FRAMEBUFFER_SHAPE_FILL_ASSERT_SVH
`define FRAMEBUFFER_SHAPE_FILL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSF_ASSERT_SAME(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSF_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ src/fsf_pkg.sv @@
package fsf_pkg;

   // Field widths.
   localparam int CRD_W     = 12;
   localparam int SGN_W     = CRD_W + 2;
   localparam int COLOR_W   = 16;
   localparam int MODE_W    = 3;
   localparam int CFG_W     = 9;
   localparam int CSR_IDX_W = 1;
   localparam int MUL_W     = 2 * CRD_W;
   localparam int PROD_W    = 2 * MUL_W;

   // Command codes.
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PIXEL   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CIRCLE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ELLIPSE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;

   // Register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 1'b1;
   localparam logic [CFG_W-1:0]     CFG_RESET         = 9'd240;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [CRD_W-1:0]   pos_x;
      logic [CRD_W-1:0]   pos_y;
      logic [CRD_W-1:0]   radius_x;
      logic [CRD_W-1:0]   radius_y;
      logic [COLOR_W-1:0] fill_color;
   } req_type;

   typedef struct packed {
      logic [MODE_W-1:0]  done_mode;
      logic [COLOR_W-1:0] read_color;
   } rsp_type;

   // Active screen size, already limited to the store size.
   typedef struct packed {
      logic [CRD_W-1:0] w;
      logic [CRD_W-1:0] h;
   } geom_type;

   // Store port control.
   typedef struct packed {
      logic               we;
      logic               re;
      logic [COLOR_W-1:0] wdata;
   } mem_ctl_type;

   // Sequencer status toward the top level.
   typedef struct packed {
      logic ready;
      logic done;
   } seq_stat_type;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLR_MUL,
      ST_CLR_RUN,
      ST_PIX_MUL,
      ST_PIX_GO,
      ST_RD_WAIT,
      ST_SH_BOX,
      ST_SH_RY,
      ST_SH_LIM,
      ST_SH_KEY,
      ST_ROW_BASE,
      ST_ROW_DY,
      ST_ROW_KY,
      ST_ROW_TERM,
      ST_PX_DX,
      ST_PX_KX,
      ST_PX_TEST,
      ST_DONE
   } state_type;

   // Distance between two coordinates.
   function automatic logic [CRD_W-1:0] abs_diff(input logic [CRD_W-1:0] a,
                                                 input logic [CRD_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

@@ src/fsf_mul.sv @@
// Shared unsigned multiplier with a registered product.
module fsf_mul (
   input  logic                       clock,
   input  logic [fsf_pkg::MUL_W-1:0]  op_a,
   input  logic [fsf_pkg::MUL_W-1:0]  op_b,
   output logic [fsf_pkg::PROD_W-1:0] prod
);

   logic [fsf_pkg::PROD_W-1:0] prod_ff;

   // The product is registered, ready in the cycle after the operands.
   always_ff @(posedge clock) begin
      prod_ff <= fsf_pkg::PROD_W'(op_a) * fsf_pkg::PROD_W'(op_b);
   end

   assign prod = prod_ff;

endmodule

@@ src/fsf_store.sv @@
// Pixel store: one address, with a write port and a registered read port.
module fsf_store #(
   parameter int DEPTH = 65536
) (
   input  logic                        clock,
   input  logic [$clog2(DEPTH)-1:0]    addr,
   input  fsf_pkg::mem_ctl_type        ctl,
   output logic [fsf_pkg::COLOR_W-1:0] rdata
);

   logic [fsf_pkg::COLOR_W-1:0] mem [DEPTH];
   logic [fsf_pkg::COLOR_W-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[addr] <= ctl.wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (ctl.re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ src/fsf_seq.sv @@
// Command sequencer: walks clear sweeps, pixel accesses and shape scans,
// driving the shared multiplier and the pixel store.
module fsf_seq #(
   parameter int DEPTH = 65536
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  fsf_pkg::req_type            req_data,
   input  fsf_pkg::geom_type           geom,
   input  logic                        out_free,
   output fsf_pkg::seq_stat_type       stat,
   output fsf_pkg::rsp_type            result,
   output logic [fsf_pkg::MUL_W-1:0]   op_a,
   output logic [fsf_pkg::MUL_W-1:0]   op_b,
   input  logic [fsf_pkg::PROD_W-1:0]  prod,
   output logic [$clog2(DEPTH)-1:0]    mem_addr,
   output fsf_pkg::mem_ctl_type        mem_ctl,
   input  logic [fsf_pkg::COLOR_W-1:0] mem_rdata
);

   localparam int AD_W  = $clog2(DEPTH);
   localparam int CNT_W = AD_W + 1;
   localparam int CW    = fsf_pkg::CRD_W;
   localparam int SW    = fsf_pkg::SGN_W;
   localparam int MW    = fsf_pkg::MUL_W;
   localparam int PW    = fsf_pkg::PROD_W;

   fsf_pkg::state_type          state_ff, state_in;
   fsf_pkg::req_type            cmd_ff, cmd_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [CW-1:0]               x_ff, x_in, y_ff, y_in;
   logic [CW-1:0]               x0_ff, x0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic [MW-1:0]               rxs_ff, rxs_in, kx_ff, kx_in, ky_ff, ky_in;
   logic [PW-1:0]               lim_ff, lim_in, rowterm_ff, rowterm_in;
   logic [AD_W-1:0]             base_ff, base_in;
   logic [fsf_pkg::COLOR_W-1:0] rd_ff, rd_in;

   logic                        ellipse;
   logic [CW-1:0]               ry_eff;
   logic signed [SW-1:0]        lo_x, hi_x, lo_y, hi_y, wm1, hm1;
   logic signed [SW-1:0]        x0s, x1s, y0s, y1s;
   logic                        box_empty;
   logic                        hit;

   assign ellipse = (cmd_ff.mode == fsf_pkg::MODE_ELLIPSE);
   assign ry_eff  = ellipse ? cmd_ff.radius_y : cmd_ff.radius_x;

   // Bounding box clipped to the screen, in signed coordinates.
   always_comb begin
      lo_x = SW'(cmd_ff.pos_x) - SW'(cmd_ff.radius_x);
      hi_x = SW'(cmd_ff.pos_x) + SW'(cmd_ff.radius_x);
      lo_y = SW'(cmd_ff.pos_y) - SW'(ry_eff);
      hi_y = SW'(cmd_ff.pos_y) + SW'(ry_eff);
      wm1  = SW'(geom.w) - SW'(1);
      hm1  = SW'(geom.h) - SW'(1);
      x0s  = (lo_x < 0) ? '0 : lo_x;
      y0s  = (lo_y < 0) ? '0 : lo_y;
      x1s  = (hi_x > wm1) ? wm1 : hi_x;
      y1s  = (hi_y > hm1) ? hm1 : hi_y;
      box_empty = (x0s > x1s) || (y0s > y1s);
   end

   // Inside test for the current pixel.
   assign hit = ({1'b0, prod} + {1'b0, rowterm_ff}) <= {1'b0, lim_ff};

   // State and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsf_pkg::ST_INIT;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      x0_ff      <= x0_in;
      x1_ff      <= x1_in;
      y1_ff      <= y1_in;
      rxs_ff     <= rxs_in;
      kx_ff      <= kx_in;
      ky_ff      <= ky_in;
      lim_ff     <= lim_in;
      rowterm_ff <= rowterm_in;
      base_ff    <= base_in;
      rd_ff      <= rd_in;
   end

   // Next state, multiplier operands and store accesses.
   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      cnt_in     = cnt_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      x0_in      = x0_ff;
      x1_in      = x1_ff;
      y1_in      = y1_ff;
      rxs_in     = rxs_ff;
      kx_in      = kx_ff;
      ky_in      = ky_ff;
      lim_in     = lim_ff;
      rowterm_in = rowterm_ff;
      base_in    = base_ff;
      rd_in      = rd_ff;
      op_a       = '0;
      op_b       = '0;
      mem_addr   = cnt_ff[AD_W-1:0];
      mem_ctl    = '{we: 1'b0, re: 1'b0, wdata: cmd_ff.fill_color};
      stat       = '{ready: 1'b0, done: 1'b0};

      unique case (state_ff)
         // Clearing pass after reset, one entry a cycle.
         fsf_pkg::ST_INIT: begin
            mem_ctl.we    = 1'b1;
            mem_ctl.wdata = '0;
            if (cnt_ff == CNT_W'(DEPTH - 1)) begin
               cnt_in   = '0;
               state_in = fsf_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end

         fsf_pkg::ST_IDLE: begin
            stat.ready = 1'b1;
            if (req_valid) begin
               cmd_in = req_data;
               rd_in  = '0;
               cnt_in = '0;
               unique case (req_data.mode)
                  fsf_pkg::MODE_CLEAR:   state_in = fsf_pkg::ST_CLR_MUL;
                  fsf_pkg::MODE_PIXEL:   state_in = fsf_pkg::ST_PIX_MUL;
                  fsf_pkg::MODE_READ:    state_in = fsf_pkg::ST_PIX_MUL;
                  fsf_pkg::MODE_CIRCLE:  state_in = fsf_pkg::ST_SH_BOX;
                  fsf_pkg::MODE_ELLIPSE: state_in = fsf_pkg::ST_SH_BOX;
                  default:               state_in = fsf_pkg::ST_DONE;
               endcase
            end
         end

         // Clear: the product holds the active pixel count.
         fsf_pkg::ST_CLR_MUL: begin
            op_a     = MW'(geom.w);
            op_b     = MW'(geom.h);
            state_in = fsf_pkg::ST_CLR_RUN;
         end

         fsf_pkg::ST_CLR_RUN: begin
            op_a = MW'(geom.w);
            op_b = MW'(geom.h);
            if (cnt_ff == prod[CNT_W-1:0]) begin
               state_in = fsf_pkg::ST_DONE;
            end else begin
               mem_ctl.we = 1'b1;
               cnt_in     = cnt_ff + CNT_W'(1);
            end
         end

         // Single pixel: row base from the multiplier, then the access.
         fsf_pkg::ST_PIX_MUL: begin
            op_a = MW'(cmd_ff.pos_y);
            op_b = MW'(geom.w);
            if ((cmd_ff.pos_x < geom.w) && (cmd_ff.pos_y < geom.h)) begin
               state_in = fsf_pkg::ST_PIX_GO;
            end else begin
               state_in = fsf_pkg::ST_DONE;
            end
         end

         fsf_pkg::ST_PIX_GO: begin
            mem_addr = prod[AD_W-1:0] + AD_W'(cmd_ff.pos_x);
            if (cmd_ff.mode == fsf_pkg::MODE_READ) begin
               mem_ctl.re = 1'b1;
               state_in   = fsf_pkg::ST_RD_WAIT;
            end else begin
               mem_ctl.we = 1'b1;
               state_in   = fsf_pkg::ST_DONE;
            end
         end

         fsf_pkg::ST_RD_WAIT: begin
            rd_in    = mem_rdata;
            state_in = fsf_pkg::ST_DONE;
         end

         // Shape setup: clip the box and form the squared radii.
         fsf_pkg::ST_SH_BOX: begin
            op_a  = MW'(cmd_ff.radius_x);
            op_b  = MW'(cmd_ff.radius_x);
            x0_in = x0s[CW-1:0];
            x1_in = x1s[CW-1:0];
            y_in  = y0s[CW-1:0];
            y1_in = y1s[CW-1:0];
            if (box_empty || (ellipse && ((cmd_ff.radius_x == '0) ||
                                          (cmd_ff.radius_y == '0)))) begin
               state_in = fsf_pkg::ST_DONE;
            end else begin
               state_in = fsf_pkg::ST_SH_RY;
            end
         end

         fsf_pkg::ST_SH_RY: begin
            op_a     = MW'(ry_eff);
            op_b     = MW'(ry_eff);
            rxs_in   = prod[MW-1:0];
            state_in = fsf_pkg::ST_SH_LIM;
         end

         fsf_pkg::ST_SH_LIM: begin
            op_a     = rxs_ff;
            op_b     = prod[MW-1:0];
            kx_in    = ellipse ? prod[MW-1:0] : MW'(1);
            state_in = fsf_pkg::ST_SH_KEY;
         end

         // A circle uses unit weights and the squared radius as limit.
         fsf_pkg::ST_SH_KEY: begin
            lim_in   = ellipse ? prod : PW'(rxs_ff);
            ky_in    = ellipse ? rxs_ff : MW'(1);
            state_in = fsf_pkg::ST_ROW_BASE;
         end

         // Per row: store base address and the weighted dy term.
         fsf_pkg::ST_ROW_BASE: begin
            op_a     = MW'(y_ff);
            op_b     = MW'(geom.w);
            state_in = fsf_pkg::ST_ROW_DY;
         end

         fsf_pkg::ST_ROW_DY: begin
            op_a     = MW'(fsf_pkg::abs_diff(y_ff, cmd_ff.pos_y));
            op_b     = MW'(fsf_pkg::abs_diff(y_ff, cmd_ff.pos_y));
            base_in  = prod[AD_W-1:0];
            state_in = fsf_pkg::ST_ROW_KY;
         end

         fsf_pkg::ST_ROW_KY: begin
            op_a     = prod[MW-1:0];
            op_b     = ky_ff;
            state_in = fsf_pkg::ST_ROW_TERM;
         end

         fsf_pkg::ST_ROW_TERM: begin
            rowterm_in = prod;
            x_in       = x0_ff;
            state_in   = fsf_pkg::ST_PX_DX;
         end

         // Per pixel: weighted dx term, then test and write.
         fsf_pkg::ST_PX_DX: begin
            op_a     = MW'(fsf_pkg::abs_diff(x_ff, cmd_ff.pos_x));
            op_b     = MW'(fsf_pkg::abs_diff(x_ff, cmd_ff.pos_x));
            state_in = fsf_pkg::ST_PX_KX;
         end

         fsf_pkg::ST_PX_KX: begin
            op_a     = prod[MW-1:0];
            op_b     = kx_ff;
            state_in = fsf_pkg::ST_PX_TEST;
         end

         fsf_pkg::ST_PX_TEST: begin
            mem_addr   = base_ff + AD_W'(x_ff);
            mem_ctl.we = hit;
            if (x_ff == x1_ff) begin
               if (y_ff == y1_ff) begin
                  state_in = fsf_pkg::ST_DONE;
               end else begin
                  y_in     = y_ff + CW'(1);
                  state_in = fsf_pkg::ST_ROW_BASE;
               end
            end else begin
               x_in     = x_ff + CW'(1);
               state_in = fsf_pkg::ST_PX_DX;
            end
         end

         // Hand the response over once the output register is free.
         fsf_pkg::ST_DONE: begin
            stat.done = 1'b1;
            if (out_free) begin
               state_in = fsf_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = fsf_pkg::ST_IDLE;
         end
      endcase
   end

   assign result = '{done_mode: cmd_ff.mode, read_color: rd_ff};

endmodule

@@ src/framebuffer_shape_fill.sv @@
// Channel   Direction  Handshake              Payload
// req       in         req_valid, req_stall   fsf_pkg::req_type (one command)
// rsp       out        rsp_valid, rsp_stall   fsf_pkg::rsp_type (one per command)
// csr       in         csr_write              csr_index, csr_data
//
// Every command with a known code runs through one shared multiplier under the sequencer,
// which sets the scan rate: each pixel takes PX_DX, PX_KX and PX_TEST, and each row adds
// ROW_BASE, ROW_DY, ROW_KY and ROW_TERM. Clear writes the w*h active entries. Set and
// read pixel skip the store off screen, and a circle or ellipse with nothing to draw goes
// straight to ST_DONE. After reset the whole store is cleared one entry a cycle, with
// req_stall high. A new command is taken while the last response waits on rsp_stall.
module framebuffer_shape_fill #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  fsf_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output fsf_pkg::rsp_type              rsp_data,
   input  logic                          csr_write,
   input  logic [fsf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fsf_pkg::CFG_W-1:0]     csr_data
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AD_W  = $clog2(DEPTH);
   localparam int CW    = fsf_pkg::CRD_W;

   logic [fsf_pkg::CFG_W-1:0]   width_ff, width_in, height_ff, height_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   fsf_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   fsf_pkg::geom_type           geom;
   fsf_pkg::seq_stat_type       stat;
   fsf_pkg::rsp_type            result;
   fsf_pkg::mem_ctl_type        mem_ctl;
   logic                        out_free;
   logic [fsf_pkg::MUL_W-1:0]   op_a, op_b;
   logic [fsf_pkg::PROD_W-1:0]  prod;
   logic [AD_W-1:0]             mem_addr;
   logic [fsf_pkg::COLOR_W-1:0] mem_rdata;

   // Screen size registers.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         if (csr_index == fsf_pkg::CSR_SCREEN_WIDTH) begin
            width_in = csr_data;
         end else begin
            height_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= fsf_pkg::CFG_RESET;
         height_ff <= fsf_pkg::CFG_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Active size, limited to the store dimensions.
   always_comb begin
      geom.w = (CW'(width_ff) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_ff);
      geom.h = (CW'(height_ff) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(height_ff);
   end

   // Response register between the sequencer and the rsp channel.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (stat.done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign req_stall = !stat.ready;

   fsf_seq #(
      .DEPTH(DEPTH)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_data (req_data),
      .geom     (geom),
      .out_free (out_free),
      .stat     (stat),
      .result   (result),
      .op_a     (op_a),
      .op_b     (op_b),
      .prod     (prod),
      .mem_addr (mem_addr),
      .mem_ctl  (mem_ctl),
      .mem_rdata(mem_rdata)
   );

   fsf_mul u_mul (
      .clock(clock),
      .op_a (op_a),
      .op_b (op_b),
      .prod (prod)
   );

   fsf_store #(
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .addr (mem_addr),
      .ctl  (mem_ctl),
      .rdata(mem_rdata)
   );

endmodule

@@ src/fsf_checker.sv @@
`include "framebuffer_shape_fill_assert.svh"

// Port-level checks on the frame store block.
module fsf_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input fsf_pkg::rsp_type rsp_data
);

   logic rsp_wait;
   logic req_take;
   logic rsp_other;

   assign rsp_wait  = rsp_valid && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign rsp_other = rsp_valid && (rsp_data.done_mode != fsf_pkg::MODE_READ);

   // A stalled response stays offered and unchanged.
   `FSF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid, "rsp dropped")
   `FSF_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_wait, $stable(rsp_data), "rsp changed")

   // Every command keeps the block busy for at least the following cycle.
   `FSF_ASSERT_NEXT(a_busy, clock, reset, req_take, req_stall, "req taken twice")

   // Only a read returns pixel data.
   `FSF_ASSERT_SAME(a_color_zero, clock, reset, rsp_other, rsp_data.read_color == '0, "color set")

endmodule

bind framebuffer_shape_fill fsf_checker u_fsf_checker (.*);
